// ----- rtl/bzp_pkg.sv -----
// Shared types and constants for the buzzer tone sequence player.
`default_nettype none
package bzp_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned POS_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned POS_OUT_W   = 6;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned DUR_W    = 8;
  localparam int unsigned PCLK_W   = 28;
  localparam int unsigned PERIOD_W = 18;
  localparam int unsigned CMP_W    = 12;
  localparam int unsigned N_W      = 8;
  localparam int unsigned TICK_W   = 17;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned DVD_W     = 30;
  localparam int unsigned DVS_W     = 26;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  localparam logic [WORD_W-1:0]   START_WORD   = 32'h0101_0001;
  localparam logic [WORD_W-1:0]   STOP_WORD    = 32'h0202_0002;
  localparam logic [FREQ_W-1:0]   DEFAULT_FREQ = 16'd524;
  localparam logic [DVS_W-1:0]    FREQ_SCALE   = 26'd800;
  localparam logic [DVS_W-1:0]    CMP_DIV      = 26'd100;
  // 9 * pclk / 12e6 reduced to 3 * pclk / 4e6 (same floor)
  localparam logic [DVD_W-1:0]    TICK_MUL     = 30'd3;
  localparam logic [DVS_W-1:0]    TICK_DIV     = 26'd4000000;
  localparam logic [N_W-1:0]      N_DEFAULT    = 8'd9;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 18'h3FFFF;

  localparam logic [PCLK_W-1:0] PCLK_RESET = 28'd6000000;

  localparam logic [CFG_IDX_W-1:0] CFG_PCLK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LTM  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_EVAL,
    ST_DIV_PER,
    ST_DIV_CMP,
    ST_DIV_TICK
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/bzp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bzp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/bzp_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module bzp_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [bzp_pkg::DVD_W-1:0]  dividend_i,
  input  wire logic [bzp_pkg::DVS_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic      [bzp_pkg::DVD_W-1:0]  quot_o
);

  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [bzp_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [bzp_pkg::DVD_W-1:0]     dvd_q, dvd_d;
  logic [bzp_pkg::DVS_W-1:0]     dvs_q, dvs_d;
  logic [bzp_pkg::DVS_W-1:0]     rem_q, rem_d;
  logic [bzp_pkg::DVS_W:0]       shifted;
  logic [bzp_pkg::DVS_W:0]       diff;
  logic                          ge;

  assign shifted = {rem_q, dvd_q[bzp_pkg::DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
    end else if (run_q) begin
      rem_d = ge ? diff[bzp_pkg::DVS_W-1:0] : shifted[bzp_pkg::DVS_W-1:0];
      dvd_d = {dvd_q[bzp_pkg::DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == bzp_pkg::DIV_CNT_W'(bzp_pkg::DVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
`default_nettype wire

// ----- rtl/buzzer_tone_sequence_player_unit.sv -----
// An append, a counted tick or an ignored command strobes done_o in the cycle after start.
// A stop word sweeps zeros through the queue and then strobes done_o.
// Playing a tone reads a queue word, then runs three bit-serial divisions in a shared divider.
// One command at a time; busy stays high until its result strobe, which cannot be stalled.
// Reset clears control and tone state but not rd_addr_q, rd_zero_q or dur_q, and restores
// pclk_q and ltm_q to their defaults; the queue RAM is not reset.
`default_nettype none
module buzzer_tone_sequence_player_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cmd_i,
  input  wire logic [bzp_pkg::WORD_W-1:0]        command_word_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bzp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [bzp_pkg::PCLK_W-1:0]        cfg_data_i,
  output logic                                   done_o,
  output logic      [bzp_pkg::PERIOD_W-1:0]      period_count_o,
  output logic      [bzp_pkg::CMP_W-1:0]         compare_count_o,
  output logic                                   tone_on_o,
  output logic                                   playing_o,
  output logic      [bzp_pkg::POS_OUT_W-1:0]     play_position_o
);

  bzp_pkg::state_e state_q, state_d;

  logic [bzp_pkg::PCLK_W-1:0]   pclk_q, pclk_d;
  logic                         ltm_q, ltm_d;
  logic [bzp_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [bzp_pkg::ADDR_W-1:0]   last_q, last_d;
  logic                         stopped_q, stopped_d;
  logic                         armed_q, armed_d;
  logic [bzp_pkg::TICK_W-1:0]   ticks_q, ticks_d;
  logic                         ton_q, ton_d;
  logic [bzp_pkg::PERIOD_W-1:0] reload_q, reload_d;
  logic [bzp_pkg::CMP_W-1:0]    cmp_q, cmp_d;
  logic [bzp_pkg::ADDR_W-1:0]   clr_q, clr_d;
  logic [bzp_pkg::ADDR_W-1:0]   rd_addr_q, rd_addr_d;
  logic                         rd_zero_q, rd_zero_d;
  logic [bzp_pkg::DUR_W-1:0]    dur_q, dur_d;
  logic                         done_q, done_d;

  logic                         acc;
  logic                         pos_room;
  logic                         clr_last;
  logic                         is_start;
  logic                         is_stop;
  logic                         expire;
  logic [bzp_pkg::WORD_W-1:0]   word;
  logic                         word_bad;
  logic [bzp_pkg::FREQ_W-1:0]   freq;
  logic [bzp_pkg::PERIOD_W-1:0] per_calc;
  logic [bzp_pkg::N_W-1:0]      n_calc;
  logic [2*bzp_pkg::N_W-1:0]    dur_prod;

  logic                         ram_we;
  logic [bzp_pkg::ADDR_W-1:0]   ram_waddr;
  logic [bzp_pkg::WORD_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [bzp_pkg::WORD_W-1:0]   ram_rdata;

  logic                         div_start;
  logic [bzp_pkg::DVD_W-1:0]    div_dvd;
  logic [bzp_pkg::DVS_W-1:0]    div_dvs;
  logic                         div_done;
  logic [bzp_pkg::DVD_W-1:0]    div_quot;

  bzp_ram #(
    .WIDTH (bzp_pkg::WORD_W),
    .DEPTH (bzp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  bzp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign acc      = start && (state_q == bzp_pkg::ST_IDLE);
  assign pos_room = pos_q < bzp_pkg::POS_W'(bzp_pkg::QUEUE_DEPTH);
  assign clr_last = clr_q == bzp_pkg::ADDR_W'(bzp_pkg::QUEUE_DEPTH - 1);
  assign is_start = command_word_i == bzp_pkg::START_WORD;
  assign is_stop  = (command_word_i == '0) || (command_word_i == bzp_pkg::STOP_WORD);
  assign expire   = armed_q && (ticks_q <= bzp_pkg::TICK_W'(1));

  assign word     = rd_zero_q ? '0 : ram_rdata;
  assign word_bad = (word == '0) || word[bzp_pkg::WORD_W-1];
  assign freq     = (word[bzp_pkg::FREQ_W-1:0] == '0) ? bzp_pkg::DEFAULT_FREQ
                                                      : word[bzp_pkg::FREQ_W-1:0];

  always_comb begin
    if (div_quot == '0) begin
      per_calc = '0;
    end else if (div_quot > bzp_pkg::DVD_W'(bzp_pkg::PERIOD_MAX) + 1'b1) begin
      per_calc = bzp_pkg::PERIOD_MAX;
    end else begin
      per_calc = bzp_pkg::PERIOD_W'(div_quot - 1'b1);
    end
  end

  assign n_calc   = (div_quot == '0) ? bzp_pkg::N_DEFAULT : bzp_pkg::N_W'(div_quot);
  assign dur_prod = dur_q * n_calc;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bzp_pkg::ST_IDLE: begin
        if (acc) begin
          if (!cmd_i) begin
            if (is_start) begin
              state_d = bzp_pkg::ST_READ;
            end else if (is_stop) begin
              state_d = bzp_pkg::ST_CLEAR;
            end
          end else if (expire && !stopped_q) begin
            state_d = bzp_pkg::ST_READ;
          end
        end
      end
      bzp_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = bzp_pkg::ST_IDLE;
        end
      end
      bzp_pkg::ST_READ: begin
        state_d = bzp_pkg::ST_EVAL;
      end
      bzp_pkg::ST_EVAL: begin
        state_d = word_bad ? bzp_pkg::ST_IDLE : bzp_pkg::ST_DIV_PER;
      end
      bzp_pkg::ST_DIV_PER: begin
        if (div_done) begin
          state_d = bzp_pkg::ST_DIV_CMP;
        end
      end
      bzp_pkg::ST_DIV_CMP: begin
        if (div_done) begin
          state_d = bzp_pkg::ST_DIV_TICK;
        end
      end
      bzp_pkg::ST_DIV_TICK: begin
        if (div_done) begin
          state_d = bzp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bzp_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q[bzp_pkg::ADDR_W-1:0];
    ram_wdata = command_word_i;
    ram_re    = 1'b0;
    div_start = 1'b0;
    div_dvd   = bzp_pkg::DVD_W'(pclk_q);
    div_dvs   = bzp_pkg::DVS_W'(freq) * bzp_pkg::FREQ_SCALE;
    done_d    = 1'b0;
    case (state_q)
      bzp_pkg::ST_IDLE: begin
        if (acc) begin
          if (!cmd_i) begin
            ram_we = pos_room && !is_stop;
            done_d = !is_start && !is_stop;
          end else begin
            done_d = !(expire && !stopped_q);
          end
        end
      end
      bzp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        done_d    = clr_last;
      end
      bzp_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      bzp_pkg::ST_EVAL: begin
        div_start = !word_bad;
        done_d    = word_bad;
      end
      bzp_pkg::ST_DIV_PER: begin
        div_start = div_done;
        div_dvd   = bzp_pkg::DVD_W'(per_calc);
        div_dvs   = bzp_pkg::CMP_DIV;
      end
      bzp_pkg::ST_DIV_CMP: begin
        div_start = div_done;
        div_dvd   = bzp_pkg::DVD_W'(pclk_q) * bzp_pkg::TICK_MUL;
        div_dvs   = bzp_pkg::TICK_DIV;
      end
      bzp_pkg::ST_DIV_TICK: begin
        done_d = div_done;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    pclk_d    = pclk_q;
    ltm_d     = ltm_q;
    pos_d     = pos_q;
    last_d    = last_q;
    stopped_d = stopped_q;
    armed_d   = armed_q;
    ticks_d   = ticks_q;
    ton_d     = ton_q;
    reload_d  = reload_q;
    cmp_d     = cmp_q;
    clr_d     = clr_q;
    rd_addr_d = rd_addr_q;
    rd_zero_d = rd_zero_q;
    dur_d     = dur_q;

    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == bzp_pkg::CFG_PCLK) begin
        pclk_d = cfg_data_i;
      end else if (cfg_index_i == bzp_pkg::CFG_LTM) begin
        ltm_d = cfg_data_i[0];
      end
    end

    case (state_q)
      bzp_pkg::ST_IDLE: begin
        if (acc) begin
          if (!cmd_i) begin
            if (is_start) begin
              last_d    = pos_room ? pos_q[bzp_pkg::ADDR_W-1:0]
                                   : bzp_pkg::ADDR_W'(bzp_pkg::QUEUE_DEPTH - 1);
              pos_d     = bzp_pkg::POS_W'(1);
              stopped_d = 1'b0;
              rd_addr_d = '0;
              rd_zero_d = 1'b0;
            end else if (is_stop) begin
              stopped_d = 1'b1;
              ton_d     = 1'b0;
              pos_d     = '0;
              clr_d     = '0;
            end else if (pos_room) begin
              pos_d = pos_q + 1'b1;
            end
          end else if (armed_q) begin
            if (!expire) begin
              ticks_d = ticks_q - 1'b1;
            end else begin
              ticks_d = '0;
              armed_d = 1'b0;
              if (!stopped_q) begin
                rd_addr_d = pos_q[bzp_pkg::ADDR_W-1:0];
                rd_zero_d = !pos_room;
                pos_d     = (pos_q >= bzp_pkg::POS_W'(last_q)) ? '0 : pos_q + 1'b1;
              end
            end
          end
        end
      end
      bzp_pkg::ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
      end
      bzp_pkg::ST_EVAL: begin
        if (word_bad) begin
          ton_d     = 1'b0;
          stopped_d = 1'b1;
        end else begin
          dur_d = word[bzp_pkg::WORD_W-1 -: bzp_pkg::DUR_W];
        end
      end
      bzp_pkg::ST_DIV_PER: begin
        if (div_done) begin
          reload_d = per_calc;
        end
      end
      bzp_pkg::ST_DIV_CMP: begin
        if (div_done) begin
          cmp_d = bzp_pkg::CMP_W'(div_quot);
        end
      end
      bzp_pkg::ST_DIV_TICK: begin
        if (div_done) begin
          ticks_d = ltm_q ? {dur_prod, 1'b0} : bzp_pkg::TICK_W'(dur_prod);
          armed_d = 1'b1;
          ton_d   = 1'b1;
        end
      end
      default: begin
        ton_d = ton_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bzp_pkg::ST_IDLE;
      pclk_q    <= bzp_pkg::PCLK_RESET;
      ltm_q     <= 1'b1;
      pos_q     <= '0;
      last_q    <= '0;
      stopped_q <= 1'b0;
      armed_q   <= 1'b0;
      ticks_q   <= '0;
      ton_q     <= 1'b0;
      reload_q  <= '0;
      cmp_q     <= '0;
      clr_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      pclk_q    <= pclk_d;
      ltm_q     <= ltm_d;
      pos_q     <= pos_d;
      last_q    <= last_d;
      stopped_q <= stopped_d;
      armed_q   <= armed_d;
      ticks_q   <= ticks_d;
      ton_q     <= ton_d;
      reload_q  <= reload_d;
      cmp_q     <= cmp_d;
      clr_q     <= clr_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    rd_zero_q <= rd_zero_d;
    dur_q     <= dur_d;
  end

  assign busy            = state_q != bzp_pkg::ST_IDLE;
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign period_count_o  = reload_q;
  assign compare_count_o = cmp_q;
  assign tone_on_o       = ton_q;
  assign playing_o       = !stopped_q;
  assign play_position_o = bzp_pkg::POS_OUT_W'(pos_q);

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a transaction is still in progress");

  a_tone_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_on_o |-> playing_o)
    else $error("tone running while playback is stopped");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy raised without an accepted transaction");

  a_clear_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bzp_pkg::ST_CLEAR && clr_last) |=> (done_o && !busy))
    else $error("queue clear did not end with a result strobe");
`endif

endmodule
`default_nettype wire
